FILE: rtl/sba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sba_pkg: shared constants, types and helpers of the sector bitmap allocator
// Field widths, action and status codes, controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package sba_pkg;

    localparam int DEF_MAX_SECTORS = 4096;
    localparam int DEF_MAX_REQUEST = 64;
    localparam int TOT_RESET       = 4096;

    localparam int WORD_W  = 64;
    localparam int BIT_W   = 6;
    localparam int TOT_W   = 13;
    localparam int SEC_W   = 12;
    localparam int ACT_W   = 2;
    localparam int REQ_W   = 7;
    localparam int ST_W    = 2;
    localparam int WIDX_W  = TOT_W - BIT_W;
    localparam int WCNT_W  = WIDX_W + 1;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    typedef logic [WORD_W-1:0] t_word;

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MARK    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd2;
    localparam logic [ST_W-1:0] ST_ZERO    = 2'd3;

    localparam logic [1:0] KIND_SIMPLE = 2'd0;
    localparam logic [1:0] KIND_ONE    = 2'd1;
    localparam logic [1:0] KIND_ALLOC  = 2'd2;

    typedef struct packed {
        logic clr;
        logic load;
        logic scan;
        logic mark_init;
        logic mark_rd;
        logic mark_ld;
        logic pick;
        logic mark_wr;
        logic one_rd;
        logic one_do;
        logic emit_simple;
    } t_cmd;

    typedef struct packed {
        logic       cfg_wr;
        logic       clr_done;
        logic [1:0] kind;
        logic       scan_found;
        logic       scan_done;
        logic       pick_any;
        logic       rem_zero;
        logic       out_free;
    } t_sts;

    function automatic t_word low_onehot(t_word v);
        return v & (~v + WORD_W'(1));
    endfunction

    function automatic logic [BIT_W-1:0] low_index(t_word v);
        t_word           oh;
        logic [BIT_W-1:0] idx;
        oh  = v & (~v + WORD_W'(1));
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (oh[i]) begin
                idx = idx | BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/sba_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sba_req_if: request channel of the sector bitmap allocator
// Valid/ready handshake with action, sector and count payload.
// ----------------------------------------------------------------------------
interface sba_req_if;
    import sba_pkg::*;
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [SEC_W-1:0] target_sector;
    logic [REQ_W-1:0] request_count;

    modport source (output valid, action, target_sector, request_count, input ready);
    modport sink   (input valid, action, target_sector, request_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/sba_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sba_rsp_if: result channel of the sector bitmap allocator
// Valid/ready handshake with granted sector, status and free count payload.
// ----------------------------------------------------------------------------
interface sba_rsp_if;
    import sba_pkg::*;
    logic             valid;
    logic             ready;
    logic [SEC_W-1:0] granted_sector;
    logic             last;
    logic [ST_W-1:0]  status;
    logic             sector_free;
    logic [TOT_W-1:0] free_count;
    logic             contiguous;

    modport source (output valid, granted_sector, last, status, sector_free, free_count,
                    contiguous, input ready);
    modport sink   (input valid, granted_sector, last, status, sector_free, free_count,
                    contiguous, output ready);
endinterface
`default_nettype wire

FILE: rtl/sba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sba_ram: generic single-write, single-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module sba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: rtl/sba_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sba_ctrl: sequencer of the sector bitmap allocator
// Steps clear pass, dispatch, bitmap scan, marking and result emission.
// ----------------------------------------------------------------------------
module sba_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output      logic          o_req_ready,
    input  wire sba_pkg::t_sts i_sts,
    output      sba_pkg::t_cmd o_cmd
);
    import sba_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DISP = 4'd2;
    localparam logic [3:0] S_EMIT = 4'd3;
    localparam logic [3:0] S_ORD  = 4'd4;
    localparam logic [3:0] S_ODO  = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_MRD  = 4'd7;
    localparam logic [3:0] S_MLD  = 4'd8;
    localparam logic [3:0] S_PICK = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.kind)
                    KIND_ONE:   n_state = S_ORD;
                    KIND_ALLOC: n_state = S_SCAN;
                    default:    n_state = S_EMIT;
                endcase
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_simple = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_ORD: begin
                o_cmd.one_rd = 1'b1;
                n_state      = S_ODO;
            end
            S_ODO: begin
                if (i_sts.out_free) begin
                    o_cmd.one_do = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_found || i_sts.scan_done) begin
                    o_cmd.mark_init = 1'b1;
                    n_state         = S_MRD;
                end
            end
            S_MRD: begin
                o_cmd.mark_rd = 1'b1;
                n_state       = S_MLD;
            end
            S_MLD: begin
                o_cmd.mark_ld = 1'b1;
                n_state       = S_PICK;
            end
            S_PICK: begin
                if (i_sts.pick_any) begin
                    o_cmd.pick = i_sts.out_free;
                end else begin
                    // write the word back, then move on or finish
                    o_cmd.mark_wr = 1'b1;
                    n_state       = i_sts.rem_zero ? S_IDLE : S_MRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_sts.cfg_wr) begin
            n_state = S_CLR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_accept_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready && !i_sts.cfg_wr) |=> (r_state == S_DISP))
        else $error("accepted request did not reach dispatch");
    a_pick_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pick |-> !i_sts.rem_zero)
        else $error("sector granted with nothing left to grant");
    a_load_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MLD) |-> ($past(r_state) == S_MRD))
        else $error("word loaded without a read the cycle before");
`endif
endmodule
`default_nettype wire

FILE: rtl/sba_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sba_dp: datapath of the sector bitmap allocator
// Bitmap RAM, total and free registers, run search, sector picking, result reg.
// ----------------------------------------------------------------------------
module sba_dp #(
    parameter int MAX_SECTORS = sba_pkg::DEF_MAX_SECTORS,
    parameter int MAX_REQUEST = sba_pkg::DEF_MAX_REQUEST
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sba_pkg::t_cmd               i_cmd,
    output      sba_pkg::t_sts               o_sts,
    input  wire logic [sba_pkg::ACT_W-1:0]   i_action,
    input  wire logic [sba_pkg::SEC_W-1:0]   i_target_sector,
    input  wire logic [sba_pkg::REQ_W-1:0]   i_request_count,
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic [sba_pkg::APB_AW-1:0]  i_paddr,
    input  wire logic [sba_pkg::APB_DW-1:0]  i_pwdata,
    output      logic [sba_pkg::APB_DW-1:0]  o_prdata,
    output      logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    output      logic [sba_pkg::SEC_W-1:0]   o_granted_sector,
    output      logic                        o_last,
    output      logic [sba_pkg::ST_W-1:0]    o_status,
    output      logic                        o_sector_free,
    output      logic [sba_pkg::TOT_W-1:0]   o_free_count,
    output      logic                        o_contiguous
);
    import sba_pkg::*;

    localparam int WORDS = (MAX_SECTORS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [TOT_W-1:0] RST_TOTAL =
        TOT_W'((MAX_SECTORS < TOT_RESET) ? MAX_SECTORS : TOT_RESET);
    localparam logic [TOT_W-1:0] MAX_TOTAL = TOT_W'(MAX_SECTORS);
    localparam logic [REQ_W-1:0] MAX_REQ   = REQ_W'(MAX_REQUEST);
    localparam t_word ALL = '1;

    logic [TOT_W-1:0]  r_total, r_free, n_free;
    logic [ACT_W-1:0]  r_act;
    logic [SEC_W-1:0]  r_sec;
    logic [REQ_W-1:0]  r_n, r_rem;
    logic [TOT_W-1:0]  r_start;
    logic              r_contig, r_first;
    logic [WIDX_W-1:0] r_mword, r_ev_word;
    logic [WCNT_W-1:0] r_rd_word;
    logic              r_ev;
    t_word             r_word, r_prev;
    logic [AW-1:0]     r_clr;

    logic              r_ovalid;
    logic [SEC_W-1:0]  r_o_sec;
    logic              r_o_last;
    logic [ST_W-1:0]   r_o_status;
    logic              r_o_sfree;
    logic [TOT_W-1:0]  r_o_free;
    logic              r_o_contig;

    logic              w_cfg;
    logic [TOT_W-1:0]  w_cfg_val;
    logic [TOT_W-1:0]  w_tm1;
    logic [WIDX_W-1:0] w_last_w;
    t_word             w_last_mask;
    logic              w_iss;
    t_word             w_free_bits, w_topmask, w_hit, w_cand;
    logic [2*WORD_W-1:0] w_ext;
    logic              w_found;
    logic [TOT_W-1:0]  w_run_end, w_run_start;
    logic              w_pick_any;
    logic [BIT_W-1:0]  w_pidx;
    logic              w_bit;
    t_word             w_one_word;
    logic [1:0]        w_kind;
    logic [ST_W-1:0]   w_simple_st;
    logic              w_out_free;

    logic              w_re, w_we;
    logic [AW-1:0]     w_raddr, w_waddr;
    t_word             w_wdata, w_rdata;

    function automatic t_word lim_mask(logic [WIDX_W-1:0] w, logic [WIDX_W-1:0] last_w,
                                       t_word last_mask);
        if (w < last_w) begin
            return '1;
        end else if (w == last_w) begin
            return last_mask;
        end
        return '0;
    endfunction

    // configuration
    assign w_cfg = i_psel && i_penable && i_pwrite && (i_paddr[APB_AW-1] == 1'b0);
    always_comb begin
        w_cfg_val = i_pwdata[TOT_W-1:0];
        if (w_cfg_val == '0) begin
            w_cfg_val = TOT_W'(1);
        end
        if (32'(w_cfg_val) > 32'(MAX_SECTORS)) begin
            w_cfg_val = MAX_TOTAL;
        end
    end
    assign o_prdata = APB_DW'(r_total);

    assign w_tm1       = r_total - TOT_W'(1);
    assign w_last_w    = w_tm1[TOT_W-1:BIT_W];
    assign w_last_mask = ALL >> (BIT_W'(WORD_W - 1) - w_tm1[BIT_W-1:0]);

    // run search: a run of r_n free sectors ending at bit p of this word
    assign w_iss       = (r_rd_word <= {1'b0, w_last_w});
    assign w_free_bits = ~w_rdata & lim_mask(r_ev_word, w_last_w, w_last_mask);
    assign w_ext       = {w_free_bits, r_prev};
    assign w_topmask   = ~(ALL >> r_n);
    always_comb begin
        for (int p = 0; p < WORD_W; p++) begin
            w_hit[p] = &(w_ext[p + WORD_W -: WORD_W] | ~w_topmask);
        end
    end
    assign w_found     = r_ev && (|w_hit);
    assign w_run_end   = {r_ev_word, low_index(w_hit)};
    assign w_run_start = w_run_end + TOT_W'(1) - TOT_W'(r_n);

    // sector picking within the loaded word
    assign w_cand = ~r_word & lim_mask(r_mword, w_last_w, w_last_mask)
                  & (r_first ? (ALL << r_start[BIT_W-1:0]) : ALL);
    assign w_pick_any = (|w_cand) && (r_rem != '0);
    assign w_pidx     = low_index(w_cand);

    // single-sector actions
    assign w_bit = w_rdata[r_sec[BIT_W-1:0]];
    always_comb begin
        w_one_word = w_rdata;
        n_free     = r_free;
        if (r_act == ACT_RELEASE) begin
            w_one_word[r_sec[BIT_W-1:0]] = 1'b0;
            if (w_bit) begin
                n_free = r_free + TOT_W'(1);
            end
        end else begin
            w_one_word[r_sec[BIT_W-1:0]] = 1'b1;
            if (!w_bit) begin
                n_free = r_free - TOT_W'(1);
            end
        end
        if (r_act == ACT_QUERY) begin
            n_free = r_free;
        end
    end

    always_comb begin
        w_kind      = KIND_SIMPLE;
        w_simple_st = ST_RANGE;
        if (r_act == ACT_ALLOC) begin
            if (r_n == '0) begin
                w_simple_st = ST_ZERO;
            end else if ((r_n > MAX_REQ) || (r_free < TOT_W'(r_n))) begin
                w_simple_st = ST_NOSPACE;
            end else begin
                w_kind = KIND_ALLOC;
            end
        end else if (TOT_W'(r_sec) < r_total) begin
            w_kind = KIND_ONE;
        end
    end

    assign w_out_free = !r_ovalid || i_out_ready;

    // memory ports
    always_comb begin
        w_re    = 1'b0;
        w_raddr = AW'(r_mword);
        if (i_cmd.scan && w_iss) begin
            w_re    = 1'b1;
            w_raddr = AW'(r_rd_word[WIDX_W-1:0]);
        end else if (i_cmd.one_rd) begin
            w_re    = 1'b1;
            w_raddr = AW'(r_sec[SEC_W-1:BIT_W]);
        end else if (i_cmd.mark_rd) begin
            w_re = 1'b1;
        end
        w_we    = 1'b0;
        w_waddr = AW'(r_mword);
        w_wdata = r_word;
        if (i_cmd.clr) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (i_cmd.one_do) begin
            w_we    = (r_act != ACT_QUERY);
            w_waddr = AW'(r_sec[SEC_W-1:BIT_W]);
            w_wdata = w_one_word;
        end else if (i_cmd.mark_wr) begin
            w_we = 1'b1;
        end
    end

    sba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= RST_TOTAL;
            r_free   <= RST_TOTAL;
            r_clr    <= '0;
            r_ev     <= 1'b0;
            r_first  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_cfg) begin
                r_total <= w_cfg_val;
                r_free  <= w_cfg_val;
                r_clr   <= '0;
            end else begin
                if (i_cmd.clr && (r_clr != AW'(WORDS - 1))) begin
                    r_clr <= r_clr + AW'(1);
                end
                if (i_cmd.mark_init) begin
                    r_free <= r_free - TOT_W'(r_n);
                end else if (i_cmd.one_do) begin
                    r_free <= n_free;
                end
            end
            if (i_cmd.load) begin
                r_ev <= 1'b0;
            end else if (i_cmd.scan) begin
                r_ev <= w_iss;
            end
            if (i_cmd.mark_init) begin
                r_first <= 1'b1;
            end else if (i_cmd.mark_wr) begin
                r_first <= 1'b0;
            end
            if (i_cmd.emit_simple || i_cmd.one_do || i_cmd.pick) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act     <= i_action;
            r_sec     <= i_target_sector;
            r_n       <= i_request_count;
            r_rd_word <= '0;
            r_prev    <= '0;
        end
        if (i_cmd.scan) begin
            if (w_iss) begin
                r_rd_word <= r_rd_word + WCNT_W'(1);
            end
            r_ev_word <= r_rd_word[WIDX_W-1:0];
            if (r_ev) begin
                r_prev <= w_free_bits;
            end
        end
        if (i_cmd.mark_init) begin
            r_contig <= w_found;
            r_start  <= w_found ? w_run_start : '0;
            r_mword  <= w_found ? w_run_start[TOT_W-1:BIT_W] : '0;
            r_rem    <= r_n;
        end
        if (i_cmd.mark_ld) begin
            r_word <= w_rdata;
        end
        if (i_cmd.pick) begin
            r_word <= r_word | low_onehot(w_cand);
            r_rem  <= r_rem - REQ_W'(1);
        end
        if (i_cmd.mark_wr) begin
            r_mword <= r_mword + WIDX_W'(1);
        end
        if (i_cmd.emit_simple) begin
            r_o_sec    <= '0;
            r_o_last   <= 1'b1;
            r_o_status <= w_simple_st;
            r_o_sfree  <= 1'b0;
            r_o_free   <= r_free;
            r_o_contig <= 1'b0;
        end else if (i_cmd.one_do) begin
            r_o_sec    <= '0;
            r_o_last   <= 1'b1;
            r_o_status <= ST_OK;
            r_o_sfree  <= (r_act == ACT_QUERY) && !w_bit;
            r_o_free   <= n_free;
            r_o_contig <= 1'b0;
        end else if (i_cmd.pick) begin
            r_o_sec    <= SEC_W'({r_mword, w_pidx});
            r_o_last   <= (r_rem == REQ_W'(1));
            r_o_status <= ST_OK;
            r_o_sfree  <= 1'b0;
            r_o_free   <= r_free;
            r_o_contig <= r_contig;
        end
    end

    assign o_sts.cfg_wr     = w_cfg;
    assign o_sts.clr_done   = (r_clr == AW'(WORDS - 1));
    assign o_sts.kind       = w_kind;
    assign o_sts.scan_found = w_found;
    assign o_sts.scan_done  = !r_ev && !w_iss;
    assign o_sts.pick_any   = w_pick_any;
    assign o_sts.rem_zero   = (r_rem == '0);
    assign o_sts.out_free   = w_out_free;

    assign o_out_valid      = r_ovalid;
    assign o_granted_sector = r_o_sec;
    assign o_last           = r_o_last;
    assign o_status         = r_o_status;
    assign o_sector_free    = r_o_sfree;
    assign o_free_count     = r_o_free;
    assign o_contiguous     = r_o_contig;
endmodule
`default_nettype wire

FILE: rtl/sector_bitmap_allocator.sv
`default_nettype none
// Release and mark-used read the sector's bitmap word and write it back; query only reads it.
// Allocate: dispatch, the scan (one 64-bit bitmap word a cycle), then a read, a load and a
// write-back per touched word with one granted sector per pick; one request at a time.
// Rejected requests are answered from dispatch without touching the bitmap.
// Reset and each write of the sector total run a clearing pass of the bitmap during which
// no request is accepted.
// ----------------------------------------------------------------------------
// sector_bitmap_allocator: first-fit sector allocator over a used/free bitmap
// Allocates runs or scattered sectors, releases, marks and queries sectors.
// ----------------------------------------------------------------------------
module sector_bitmap_allocator #(
    parameter int MAX_SECTORS = sba_pkg::DEF_MAX_SECTORS,
    parameter int MAX_REQUEST = sba_pkg::DEF_MAX_REQUEST
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    sba_req_if.sink                          i_req,
    sba_rsp_if.source                        o_rsp,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sba_pkg::APB_AW-1:0]  paddr,
    input  wire logic [sba_pkg::APB_DW-1:0]  pwdata,
    output      logic [sba_pkg::APB_DW-1:0]  prdata,
    output      logic                        pready
);
    import sba_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    assign pready      = 1'b1;
    assign i_req.ready = w_ready;

    sba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sba_dp #(
        .MAX_SECTORS (MAX_SECTORS),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_action         (i_req.action),
        .i_target_sector  (i_req.target_sector),
        .i_request_count  (i_req.request_count),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_prdata         (prdata),
        .o_out_valid      (o_rsp.valid),
        .i_out_ready      (o_rsp.ready),
        .o_granted_sector (o_rsp.granted_sector),
        .o_last           (o_rsp.last),
        .o_status         (o_rsp.status),
        .o_sector_free    (o_rsp.sector_free),
        .o_free_count     (o_rsp.free_count),
        .o_contiguous     (o_rsp.contiguous)
    );
endmodule
`default_nettype wire
